// ===== sv/dtss_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtss_pkg: DMA transfer size splitter package
// Limits, widths and the microcode table of the split search sequencer.
// ----------------------------------------------------------------------------
package dtss_pkg;

    localparam int MAX_MICROBLOCK = 65535;
    localparam int MAX_BLOCKS     = 4096;

    localparam int N_W     = 28;                           // transfer_count
    localparam int LEN_W   = 16;                           // microblock_len
    localparam int CNT_W   = 12;                           // block_count_minus_one
    localparam int LIM_W   = $clog2(MAX_MICROBLOCK + 1);   // candidate / divisor
    localparam int BLK_W   = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W   = LIM_W + BLK_W + N_W;          // room for cand * blocks
    localparam int DIV_CNT_W = $clog2(N_W + 1);
    localparam int STEP_W  = 4;

    // datapath action of one control word
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_LOAD_IN,
        ACT_DIV_CAND,
        ACT_DIV_N,
        ACT_DIV_STEP,
        ACT_TAKE_CAND,
        ACT_INC_I,
        ACT_SET_SINGLE,
        ACT_SET_SPLIT,
        ACT_SET_UNSUP,
        ACT_EMIT
    } t_act;

    // jump condition: taken means go to target, else fall through
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_SMALL,
        COND_DIV_BUSY,
        COND_CAND_FAIL,
        COND_NOT_FIT,
        COND_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CAND   = 4'd2;
    localparam logic [STEP_W-1:0] STEP_CWAIT  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_NWAIT  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SINGLE = 4'd10;
    localparam logic [STEP_W-1:0] STEP_UNSUP  = 4'd11;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd12;

    function automatic t_uword f_ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{act: ACT_NONE, cond: COND_ALWAYS, target: STEP_IDLE};
        case (step)
            4'd0:  w = '{act: ACT_LOAD_IN,    cond: COND_NO_IN,     target: STEP_IDLE};
            4'd1:  w = '{act: ACT_NONE,       cond: COND_SMALL,     target: STEP_SINGLE};
            4'd2:  w = '{act: ACT_DIV_CAND,   cond: COND_NEVER,     target: STEP_IDLE};
            4'd3:  w = '{act: ACT_DIV_STEP,   cond: COND_DIV_BUSY,  target: STEP_CWAIT};
            4'd4:  w = '{act: ACT_TAKE_CAND,  cond: COND_NEVER,     target: STEP_IDLE};
            4'd5:  w = '{act: ACT_NONE,       cond: COND_CAND_FAIL, target: STEP_UNSUP};
            4'd6:  w = '{act: ACT_DIV_N,      cond: COND_NEVER,     target: STEP_IDLE};
            4'd7:  w = '{act: ACT_DIV_STEP,   cond: COND_DIV_BUSY,  target: STEP_NWAIT};
            4'd8:  w = '{act: ACT_INC_I,      cond: COND_NOT_FIT,   target: STEP_CAND};
            4'd9:  w = '{act: ACT_SET_SPLIT,  cond: COND_ALWAYS,    target: STEP_EMIT};
            4'd10: w = '{act: ACT_SET_SINGLE, cond: COND_ALWAYS,    target: STEP_EMIT};
            4'd11: w = '{act: ACT_SET_UNSUP,  cond: COND_NEVER,     target: STEP_IDLE};
            4'd12: w = '{act: ACT_EMIT,       cond: COND_OUT_BUSY,  target: STEP_EMIT};
            4'd13: w = '{act: ACT_NONE,       cond: COND_ALWAYS,    target: STEP_IDLE};
            default: w = '{act: ACT_NONE,     cond: COND_ALWAYS,    target: STEP_IDLE};
        endcase
        return w;
    endfunction

endpackage

// ===== sv/dma_transfer_size_splitter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_transfer_size_splitter_top: DMA transfer size splitter
// Splits a transfer length into a microblock length and block count by a
// microcoded search over candidate sizes limit/i, sharing one serial divider.
// ----------------------------------------------------------------------------
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_transfer_count
// result    out        o_valid / i_stall   o_split_mode, o_microblock_len,
//                                          o_block_count_minus_one, o_unsupported
//
// A length up to the microblock limit goes straight to a single result; a
// longer one tries candidates in turn, each with two serial restoring
// divisions (limit/i, then length/candidate), and is split by the first that
// divides it exactly into at most the block limit of blocks. The search gives
// up once the candidate is zero, i reaches the limit or candidate * block
// limit falls below the length. Reset (synchronous, active low) clears the
// step counter and output valid. A result held by i_stall keeps o_stall high
// until it loads; the next transfer is taken after that, back at idle.
// ----------------------------------------------------------------------------
module dma_transfer_size_splitter_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [dtss_pkg::N_W-1:0]     i_transfer_count,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_split_mode,
    output logic [dtss_pkg::LEN_W-1:0]   o_microblock_len,
    output logic [dtss_pkg::CNT_W-1:0]   o_block_count_minus_one,
    output logic                         o_unsupported
);

    localparam int N_W   = dtss_pkg::N_W;
    localparam int LIM_W = dtss_pkg::LIM_W;
    localparam int CMP_W = dtss_pkg::CMP_W;
    localparam int DCW   = dtss_pkg::DIV_CNT_W;

    localparam logic [N_W-1:0]   LIMIT_N   = N_W'(dtss_pkg::MAX_MICROBLOCK);
    localparam logic [LIM_W-1:0] LIMIT_L   = LIM_W'(dtss_pkg::MAX_MICROBLOCK);
    localparam logic [N_W-1:0]   BLOCKS_N  = N_W'(dtss_pkg::MAX_BLOCKS);
    localparam logic [CMP_W-1:0] BLOCKS_C  = CMP_W'(dtss_pkg::MAX_BLOCKS);
    localparam logic [DCW-1:0]   DIV_STEPS = DCW'(N_W);

    logic [dtss_pkg::STEP_W-1:0] r_step, n_step;
    dtss_pkg::t_uword            w_uw;
    logic                        w_cond;
    logic                        w_in_acc;
    logic                        w_out_free;

    logic [N_W-1:0]   r_n;
    logic [LIM_W-1:0] r_i;
    logic [LIM_W-1:0] r_cand;

    // serial restoring divider
    logic [N_W-1:0]   r_quo;
    logic [LIM_W-1:0] r_rem;
    logic [LIM_W-1:0] r_den;
    logic [DCW-1:0]   r_div_cnt;
    logic [LIM_W:0]   w_rem_sh;
    logic             w_sub_ok;
    logic [LIM_W:0]   w_rem_sub;

    logic [CMP_W-1:0] w_cand_cap;
    logic [N_W-1:0]   w_blocks_m1;

    logic                               r_res_split;
    logic [dtss_pkg::LEN_W-1:0]         r_res_len;
    logic [dtss_pkg::CNT_W-1:0]         r_res_cnt;
    logic                               r_res_unsup;
    logic                               r_out_valid;

    assign w_uw       = dtss_pkg::f_ucode(r_step);
    assign o_stall    = (r_step != dtss_pkg::STEP_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_rem_sh   = {r_rem, r_quo[N_W-1]};
    assign w_sub_ok   = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub  = w_rem_sh - {1'b0, r_den};

    assign w_cand_cap  = CMP_W'(r_cand) * BLOCKS_C;
    assign w_blocks_m1 = r_quo - N_W'(1);

    always_comb begin
        case (w_uw.cond)
            dtss_pkg::COND_NEVER:     w_cond = 1'b0;
            dtss_pkg::COND_ALWAYS:    w_cond = 1'b1;
            dtss_pkg::COND_NO_IN:     w_cond = !w_in_acc;
            dtss_pkg::COND_SMALL:     w_cond = (r_n <= LIMIT_N);
            dtss_pkg::COND_DIV_BUSY:  w_cond = (r_div_cnt != DCW'(1));
            dtss_pkg::COND_CAND_FAIL: w_cond = (r_cand == '0) || (r_i >= LIMIT_L)
                                             || (CMP_W'(r_n) > w_cand_cap);
            dtss_pkg::COND_NOT_FIT:   w_cond = (r_rem != '0) || (r_quo > BLOCKS_N);
            dtss_pkg::COND_OUT_BUSY:  w_cond = !w_out_free;
            default:                  w_cond = 1'b0;
        endcase
    end

    assign n_step = w_cond ? w_uw.target : r_step + dtss_pkg::STEP_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= dtss_pkg::STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (w_uw.act)
            dtss_pkg::ACT_LOAD_IN: begin
                if (w_in_acc) begin
                    r_n <= i_transfer_count;
                    r_i <= LIM_W'(2);
                end
            end
            dtss_pkg::ACT_DIV_CAND: begin
                r_quo     <= LIMIT_N;
                r_rem     <= '0;
                r_den     <= r_i;
                r_div_cnt <= DIV_STEPS;
            end
            dtss_pkg::ACT_DIV_N: begin
                r_quo     <= r_n;
                r_rem     <= '0;
                r_den     <= r_cand;
                r_div_cnt <= DIV_STEPS;
            end
            dtss_pkg::ACT_DIV_STEP: begin
                r_rem     <= w_sub_ok ? w_rem_sub[LIM_W-1:0] : w_rem_sh[LIM_W-1:0];
                r_quo     <= {r_quo[N_W-2:0], w_sub_ok};
                r_div_cnt <= r_div_cnt - DCW'(1);
            end
            dtss_pkg::ACT_TAKE_CAND: begin
                r_cand <= r_quo[LIM_W-1:0];
            end
            dtss_pkg::ACT_INC_I: begin
                r_i <= r_i + LIM_W'(1);
            end
            dtss_pkg::ACT_SET_SINGLE: begin
                r_res_split <= 1'b0;
                r_res_len   <= r_n[dtss_pkg::LEN_W-1:0];
                r_res_cnt   <= '0;
                r_res_unsup <= 1'b0;
            end
            dtss_pkg::ACT_SET_SPLIT: begin
                r_res_split <= 1'b1;
                r_res_len   <= dtss_pkg::LEN_W'(r_cand);
                r_res_cnt   <= w_blocks_m1[dtss_pkg::CNT_W-1:0];
                r_res_unsup <= 1'b0;
            end
            dtss_pkg::ACT_SET_UNSUP: begin
                r_res_split <= 1'b0;
                r_res_len   <= '0;
                r_res_cnt   <= '0;
                r_res_unsup <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // output register: load on emit when free, drop valid once transferred
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_uw.act == dtss_pkg::ACT_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uw.act == dtss_pkg::ACT_EMIT && w_out_free) begin
            o_split_mode            <= r_res_split;
            o_microblock_len        <= r_res_len;
            o_block_count_minus_one <= r_res_cnt;
            o_unsupported           <= r_res_unsup;
        end
    end

    assign o_valid = r_out_valid;

endmodule
